/* design/kmpq_pkg.sv */
package kmpq_pkg;

  localparam int OP_W       = 2;
  localparam int KEY_FIELD_W = 8;
  localparam int PRIO_FIELD_W = 32;
  localparam int COUNT_FIELD_W = 5;
  localparam int OCC_FIELD_W = 9;
  localparam int RESULT_LIMIT = 16;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 2'd0,
    OP_REMOVE = 2'd1,
    OP_PICK   = 2'd2,
    OP_PEEK   = 2'd3
  } op_e;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_DISPATCH = 6'b000100,
    ST_SCAN     = 6'b001000,
    ST_FLUSH    = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_e;

  typedef struct packed {
    logic clear_step;
    logic apply_op;
    logic start_scan;
    logic step_scan;
    logic emit_none;
    logic emit_top;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic rem_zero;
    logic empty;
    logic scan_last;
    logic pop_last;
    logic out_free;
  } status_t;

endpackage

/* design/kmpq_if.sv */
interface kmpq_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [kmpq_pkg::OP_W-1:0]              operation;
  logic [kmpq_pkg::KEY_FIELD_W-1:0]       node_key;
  logic signed [kmpq_pkg::PRIO_FIELD_W-1:0] new_priority;
  logic [kmpq_pkg::COUNT_FIELD_W-1:0]     pick_count;

  modport source (output valid, operation, node_key, new_priority, pick_count, input ready);
  modport sink (input valid, operation, node_key, new_priority, pick_count, output ready);
endinterface

interface kmpq_out_if;
  logic                             valid;
  logic                             ready;
  logic [kmpq_pkg::KEY_FIELD_W-1:0] result_key;
  logic                             found;
  logic                             last_of_run;
  logic [kmpq_pkg::OCC_FIELD_W-1:0] occupancy;

  modport source (output valid, result_key, found, last_of_run, occupancy, input ready);
  modport sink (input valid, result_key, found, last_of_run, occupancy, output ready);
endinterface

/* design/kmpq_ctrl.sv */
module kmpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kmpq_pkg::status_t status_i,
  output kmpq_pkg::cmd_t    cmd_o
);

  kmpq_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == kmpq_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      kmpq_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = kmpq_pkg::ST_IDLE;
        end
      end
      kmpq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = kmpq_pkg::ST_DISPATCH;
        end
      end
      kmpq_pkg::ST_DISPATCH: begin
        if (status_i.op == kmpq_pkg::OP_UPDATE || status_i.op == kmpq_pkg::OP_REMOVE) begin
          cmd_o.apply_op = 1'b1;
          state_d = kmpq_pkg::ST_IDLE;
        end else if (status_i.empty ||
                     (status_i.op == kmpq_pkg::OP_PICK && status_i.rem_zero)) begin
          if (status_i.out_free) begin
            cmd_o.emit_none = 1'b1;
            state_d = kmpq_pkg::ST_IDLE;
          end
        end else begin
          cmd_o.start_scan = 1'b1;
          state_d = kmpq_pkg::ST_SCAN;
        end
      end
      kmpq_pkg::ST_SCAN: begin
        cmd_o.step_scan = 1'b1;
        if (status_i.scan_last) begin
          state_d = kmpq_pkg::ST_FLUSH;
        end
      end
      kmpq_pkg::ST_FLUSH: begin
        state_d = kmpq_pkg::ST_EMIT;
      end
      kmpq_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_top = 1'b1;
          if (status_i.op == kmpq_pkg::OP_PEEK || status_i.pop_last) begin
            state_d = kmpq_pkg::ST_IDLE;
          end else begin
            cmd_o.start_scan = 1'b1;
            state_d = kmpq_pkg::ST_SCAN;
          end
        end
      end
      default: begin
        state_d = kmpq_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmpq_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/kmpq_datapath.sv */
module kmpq_datapath #(
  parameter int KEYS           = 256,
  parameter int PRIORITY_WIDTH = 32,
  parameter int MAX_PICK       = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     accept_i,
  input  logic [kmpq_pkg::OP_W-1:0]                operation_i,
  input  logic [kmpq_pkg::KEY_FIELD_W-1:0]         node_key_i,
  input  logic signed [kmpq_pkg::PRIO_FIELD_W-1:0] new_priority_i,
  input  logic [kmpq_pkg::COUNT_FIELD_W-1:0]       pick_count_i,
  input  kmpq_pkg::cmd_t                           cmd_i,
  output kmpq_pkg::status_t                        status_o,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [kmpq_pkg::KEY_FIELD_W-1:0]         result_key_o,
  output logic                                     found_o,
  output logic                                     last_of_run_o,
  output logic [kmpq_pkg::OCC_FIELD_W-1:0]         occupancy_o
);

  localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CNT_W = $clog2(KEYS + 1);
  localparam int PICK_LIMIT = (MAX_PICK < kmpq_pkg::RESULT_LIMIT) ? MAX_PICK
                                                                  : kmpq_pkg::RESULT_LIMIT;

  logic [PRIORITY_WIDTH-1:0] prio_mem [KEYS];
  logic                      present_mem [KEYS];

  kmpq_pkg::op_e                      op_q;
  logic [kmpq_pkg::COUNT_FIELD_W-1:0] rem_q;
  logic [CNT_W-1:0]                   count_q;
  logic [KEY_W-1:0]                   key_q;
  logic                               key_ok_q;
  logic                               key_pres_q;

  logic [KEY_W-1:0]          scan_idx_q;
  logic [KEY_W-1:0]          cmp_idx_q;
  logic                      cmp_vld_q;
  logic                      cmp_pres_q;
  logic [PRIORITY_WIDTH-1:0] rd_data_q;
  logic                      best_found_q;
  logic [PRIORITY_WIDTH-1:0] best_prio_q;
  logic [KEY_W-1:0]          best_key_q;

  logic [KEY_W-1:0]          key_idx;
  logic                      key_ok;
  logic [PRIORITY_WIDTH-1:0] biased_prio;
  logic                      prio_wr;
  logic                      do_update;
  logic                      do_remove;
  logic                      do_pop;
  logic                      out_free;

  assign key_idx     = KEY_W'(node_key_i);
  assign key_ok      = (32'(node_key_i) < KEYS);
  assign biased_prio = PRIORITY_WIDTH'(new_priority_i) ^
                       {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};
  assign prio_wr     = accept_i && (kmpq_pkg::op_e'(operation_i) == kmpq_pkg::OP_UPDATE) &&
                       key_ok;
  assign do_update   = cmd_i.apply_op && (op_q == kmpq_pkg::OP_UPDATE) && key_ok_q;
  assign do_remove   = cmd_i.apply_op && (op_q == kmpq_pkg::OP_REMOVE) && key_ok_q;
  assign do_pop      = cmd_i.emit_top && (op_q == kmpq_pkg::OP_PICK);
  assign out_free    = !out_valid_o || out_ready_i;

  assign status_o.op        = op_q;
  assign status_o.rem_zero  = (rem_q == '0);
  assign status_o.empty     = (count_q == '0);
  assign status_o.scan_last = (scan_idx_q == KEY_W'(KEYS - 1));
  assign status_o.pop_last  = (rem_q == kmpq_pkg::COUNT_FIELD_W'(1)) ||
                              (count_q == CNT_W'(1));
  assign status_o.out_free  = out_free;

  always_ff @(posedge clk_i) begin
    if (prio_wr) begin
      prio_mem[key_idx] <= biased_prio;
    end
    rd_data_q <= prio_mem[scan_idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      present_mem[scan_idx_q] <= 1'b0;
    end else if (do_update) begin
      present_mem[key_q] <= 1'b1;
    end else if (do_remove) begin
      present_mem[key_q] <= 1'b0;
    end else if (do_pop) begin
      present_mem[best_key_q] <= 1'b0;
    end
    cmp_pres_q <= present_mem[scan_idx_q];
    key_pres_q <= present_mem[key_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      op_q     <= kmpq_pkg::OP_UPDATE;
      rem_q    <= '0;
      key_q    <= '0;
      key_ok_q <= 1'b0;
    end else begin
      if (accept_i) begin
        op_q     <= kmpq_pkg::op_e'(operation_i);
        key_q    <= key_idx;
        key_ok_q <= key_ok;
        rem_q    <= (32'(pick_count_i) > PICK_LIMIT) ? kmpq_pkg::COUNT_FIELD_W'(PICK_LIMIT)
                                                     : pick_count_i;
      end else if (do_pop) begin
        rem_q <= rem_q - kmpq_pkg::COUNT_FIELD_W'(1);
      end
      if (do_update) begin
        if (!key_pres_q) begin
          count_q <= count_q + CNT_W'(1);
        end
      end else if (do_remove) begin
        if (key_pres_q) begin
          count_q <= count_q - CNT_W'(1);
        end
      end else if (do_pop) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q   <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      best_found_q <= 1'b0;
      best_prio_q  <= '0;
      best_key_q   <= '0;
    end else begin
      cmp_vld_q  <= cmd_i.step_scan;
      cmp_idx_q  <= scan_idx_q;
      if (cmd_i.start_scan) begin
        scan_idx_q <= '0;
      end else if (cmd_i.step_scan || cmd_i.clear_step) begin
        scan_idx_q <= status_o.scan_last ? '0 : scan_idx_q + KEY_W'(1);
      end
      if (cmd_i.start_scan) begin
        best_found_q <= 1'b0;
      end else if (cmp_vld_q && cmp_pres_q && (!best_found_q || rd_data_q > best_prio_q)) begin
        best_found_q <= 1'b1;
        best_prio_q  <= rd_data_q;
        best_key_q   <= cmp_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_none || cmd_i.emit_top) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_none) begin
      result_key_o  <= '0;
      found_o       <= 1'b0;
      last_of_run_o <= 1'b1;
      occupancy_o   <= kmpq_pkg::OCC_FIELD_W'(count_q);
    end else if (cmd_i.emit_top) begin
      result_key_o  <= kmpq_pkg::KEY_FIELD_W'(best_key_q);
      found_o       <= 1'b1;
      last_of_run_o <= (op_q == kmpq_pkg::OP_PEEK) || status_o.pop_last;
      occupancy_o   <= do_pop ? kmpq_pkg::OCC_FIELD_W'(count_q - CNT_W'(1))
                              : kmpq_pkg::OCC_FIELD_W'(count_q);
    end
  end

endmodule

/* design/keyed_max_priority_queue.sv */
// Keyed max-priority queue over KEYS keys, each absent or queued with one signed
// priority; ties go to the lowest key. After reset the block clears its presence
// memory with its input held not ready. An update or remove gives no result. Every
// search for the top key walks the whole priority memory through its single read
// port, one entry per cycle, then passes a flush state before its result is emitted;
// a peek answers after one search, and a pick pops its keys one per full search.
// An empty queue or a pick count of zero answers with one beat whose found bit is
// clear. The input is ready again in the cycle in which the last beat of an item
// appears. A result beat waits in an output register until it is taken, and a search
// that finishes while a beat still waits holds until the register is free.
module keyed_max_priority_queue #(
  parameter int KEYS           = 256,
  parameter int PRIORITY_WIDTH = 32,
  parameter int MAX_PICK       = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kmpq_in_if.sink    in_i,
  kmpq_out_if.source out_o
);

  kmpq_pkg::cmd_t    cmd;
  kmpq_pkg::status_t status;
  logic              accept;

  assign accept = in_i.valid && in_i.ready;

  kmpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  kmpq_datapath #(
    .KEYS           (KEYS),
    .PRIORITY_WIDTH (PRIORITY_WIDTH),
    .MAX_PICK       (MAX_PICK)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .operation_i    (in_i.operation),
    .node_key_i     (in_i.node_key),
    .new_priority_i (in_i.new_priority),
    .pick_count_i   (in_i.pick_count),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .result_key_o   (out_o.result_key),
    .found_o        (out_o.found),
    .last_of_run_o  (out_o.last_of_run),
    .occupancy_o    (out_o.occupancy)
  );

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_top || cmd.emit_none) |-> status.out_free)
    else $error("Result register loaded while a beat was still waiting.");

  a_not_found_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.found) |-> out_o.last_of_run)
    else $error("A beat without a key was not marked last.");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.step_scan || cmd.emit_top) |-> !in_i.ready)
    else $error("Input accepted while a search was running.");

endmodule
